// ===== hw/rtl/assert_macros.svh =====
// shared assertion macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define HCCG_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");

// next-cycle implication
`define HCCG_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== hw/rtl/hccg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package hccg_pkg;

   localparam int MUL_A_W = 28;
   localparam int MUL_B_W = 25;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   typedef struct packed {
      logic               en;
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

   typedef struct packed {
      logic start;
      logic ack;
   } seq_ctl_type;

   typedef struct packed {
      logic idle;
      logic done;
   } seq_stat_type;

endpackage

`default_nettype wire

// ===== hw/rtl/hue_cycle_hsv_color_generator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Hue-cycling color generator. Each request carries an elapsed time (unsigned Q0.16
// seconds); the block advances its hue phase by hue_speed * elapsed_time modulo one
// turn and returns one result with the main color (phase, configured saturation and
// brightness) and the complementary color (phase plus half a turn, saturation x0.7,
// brightness x1.3, channels clamped at 255), both as 8-bit RGB. Every product goes
// through one shared registered multiplier in turn (phase advance, then per color one
// fraction product and two products for each of the four channel values), so the next
// request is taken only after the last result has moved on to the output register. A
// finished result waits in the output register, and a new request is accepted while
// it does. Registers at byte addresses 0x0 hue_speed (Q4.12 turns per second), 0x4
// saturation, 0x8 brightness; write only while no request is in flight.
module hue_cycle_hsv_color_generator (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [15:0] req_tdata,      // elapsed_time
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   // main_red, main_green, main_blue, comp_red, comp_green, comp_blue
   output logic [47:0] rsp_tdata,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [3:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import hccg_pkg::*;

   localparam logic [1:0] REG_HUE_SPEED  = 2'd0;
   localparam logic [1:0] REG_SATURATION = 2'd1;
   localparam logic [1:0] REG_BRIGHTNESS = 2'd2;

   logic [15:0] hue_speed_ff, hue_speed_in;
   logic [7:0]  saturation_ff, saturation_in;
   logic [7:0]  brightness_ff, brightness_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [47:0] rsp_data_ff, rsp_data_in;

   seq_ctl_type  ctl;
   seq_stat_type stat;
   mul_req_type  mul_req;
   logic [PROD_W-1:0] prod;
   logic [23:0] main_rgb;
   logic [23:0] comp_rgb;
   logic        csr_wr;
   logic [1:0]  csr_index;

   assign csr_index  = csr_paddr[3:2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      hue_speed_in  = hue_speed_ff;
      saturation_in = saturation_ff;
      brightness_in = brightness_ff;
      if (csr_wr) begin
         case (csr_index)
            REG_HUE_SPEED:  hue_speed_in  = csr_pwdata[15:0];
            REG_SATURATION: saturation_in = csr_pwdata[7:0];
            REG_BRIGHTNESS: brightness_in = csr_pwdata[7:0];
            default: hue_speed_in = hue_speed_ff;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_HUE_SPEED:  csr_prdata = 32'(hue_speed_ff);
         REG_SATURATION: csr_prdata = 32'(saturation_ff);
         REG_BRIGHTNESS: csr_prdata = 32'(brightness_ff);
         default: csr_prdata = 32'h0000_0000;
      endcase
   end

   assign req_tready = stat.idle;
   assign ctl.start  = req_tvalid & stat.idle;
   assign ctl.ack    = stat.done & (~rsp_valid_ff | rsp_tready);

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (ctl.ack) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {comp_rgb, main_rgb};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hue_speed_ff  <= 16'd4096;
         saturation_ff <= 8'd255;
         brightness_ff <= 8'd200;
         rsp_valid_ff  <= 1'b0;
      end else begin
         hue_speed_ff  <= hue_speed_in;
         saturation_ff <= saturation_in;
         brightness_ff <= brightness_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   hccg_seq u_seq (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .stat         (stat),
      .elapsed_time (req_tdata),
      .hue_speed    (hue_speed_ff),
      .saturation   (saturation_ff),
      .brightness   (brightness_ff),
      .mul_req      (mul_req),
      .prod         (prod),
      .main_rgb     (main_rgb),
      .comp_rgb     (comp_rgb)
   );

   hccg_mul u_mul (
      .clock   (clock),
      .mul_req (mul_req),
      .prod    (prod)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/hccg_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none

module hccg_mul (
   input  wire                          clock,
   input  wire hccg_pkg::mul_req_type   mul_req,
   output logic [hccg_pkg::PROD_W-1:0]  prod
);
   import hccg_pkg::*;

   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_req.a) * PROD_W'(mul_req.b);

   always_ff @(posedge clock) begin
      if (mul_req.en) begin
         prod_ff <= prod_in;
      end
   end

   assign prod = prod_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/hccg_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module hccg_seq (
   input  wire                          clock,
   input  wire                          reset,
   input  wire hccg_pkg::seq_ctl_type   ctl,
   output hccg_pkg::seq_stat_type       stat,
   input  wire  [15:0]                  elapsed_time,
   input  wire  [15:0]                  hue_speed,
   input  wire  [7:0]                   saturation,
   input  wire  [7:0]                   brightness,
   output hccg_pkg::mul_req_type        mul_req,
   input  wire  [hccg_pkg::PROD_W-1:0]  prod,
   output logic [23:0]                  main_rgb,
   output logic [23:0]                  comp_rgb
);
   import hccg_pkg::*;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_ADV   = 4'd1;
   localparam logic [3:0] ST_PHASE = 4'd2;
   localparam logic [3:0] ST_FRAC  = 4'd3;
   localparam logic [3:0] ST_FS    = 4'd4;
   localparam logic [3:0] ST_FSL   = 4'd5;
   localparam logic [3:0] ST_XSEL  = 4'd6;
   localparam logic [3:0] ST_MV    = 4'd7;
   localparam logic [3:0] ST_MD    = 4'd8;
   localparam logic [3:0] ST_QUO   = 4'd9;
   localparam logic [3:0] ST_MAP   = 4'd10;
   localparam logic [3:0] ST_DONE  = 4'd11;

   localparam logic [1:0] CH_V = 2'd0;
   localparam logic [1:0] CH_P = 2'd1;
   localparam logic [1:0] CH_Q = 2'd2;
   localparam logic [1:0] CH_T = 2'd3;

   localparam logic [27:0] BASE_MAIN  = 28'd16711680;
   localparam logic [27:0] BASE_COMP  = 28'd167116800;
   localparam logic [24:0] RECIP_MAIN = 25'd65794;
   localparam logic [24:0] RECIP_COMP = 25'd21559052;

   logic [3:0]  state_ff, state_in;
   logic        color_ff, color_in;
   logic [1:0]  chan_ff, chan_in;
   logic [15:0] dt_ff, dt_in;
   logic [15:0] phase_ff, phase_in;
   logic [2:0]  sector_ff, sector_in;
   logic [15:0] f_ff, f_in;
   logic [26:0] fs_ff, fs_in;
   logic [27:0] x_ff, x_in;
   logic [7:0]  val_ff [4];
   logic [7:0]  val_in [4];
   logic [23:0] main_rgb_ff, main_rgb_in;
   logic [23:0] comp_rgb_ff, comp_rgb_in;

   logic [11:0] vn;
   logic [10:0] sn;
   logic [27:0] base;
   logic [24:0] recip;
   logic [15:0] hp;
   logic [18:0] h6;
   logic [27:0] sn_hi;
   logic [9:0]  qraw;
   logic [7:0]  qsat;
   logic [23:0] rgb_sel;

   assign vn    = color_ff ? (12'({brightness, 3'b000}) + 12'({brightness, 2'b00})
                              + 12'(brightness))
                           : 12'(brightness);
   assign sn    = color_ff ? (11'({saturation, 3'b000}) - 11'(saturation))
                           : 11'(saturation);
   assign base  = color_ff ? BASE_COMP : BASE_MAIN;
   assign recip = color_ff ? RECIP_COMP : RECIP_MAIN;
   assign hp    = color_ff ? (phase_ff + 16'h8000) : phase_ff;
   assign h6    = 19'({hp, 2'b00}) + 19'({hp, 1'b0});
   assign sn_hi = 28'({sn, 16'h0000});
   assign qraw  = color_ff ? prod[48:39] : 10'(prod[32:24]);
   assign qsat  = (qraw > 10'd255) ? 8'hFF : qraw[7:0];

   // six-sector channel selection, result packed blue:green:red
   always_comb begin
      case (sector_ff)
         3'd0: rgb_sel = {val_ff[CH_P], val_ff[CH_T], val_ff[CH_V]};
         3'd1: rgb_sel = {val_ff[CH_P], val_ff[CH_V], val_ff[CH_Q]};
         3'd2: rgb_sel = {val_ff[CH_T], val_ff[CH_V], val_ff[CH_P]};
         3'd3: rgb_sel = {val_ff[CH_V], val_ff[CH_Q], val_ff[CH_P]};
         3'd4: rgb_sel = {val_ff[CH_V], val_ff[CH_P], val_ff[CH_T]};
         default: rgb_sel = {val_ff[CH_Q], val_ff[CH_P], val_ff[CH_V]};
      endcase
   end

   // operand selection for the shared multiplier
   always_comb begin
      mul_req = '0;
      case (state_ff)
         ST_ADV: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(hue_speed);
            mul_req.b  = MUL_B_W'(dt_ff);
         end
         ST_FS: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(f_ff);
            mul_req.b  = MUL_B_W'(sn);
         end
         ST_MV: begin
            mul_req.en = 1'b1;
            mul_req.a  = x_ff;
            mul_req.b  = MUL_B_W'(vn);
         end
         ST_MD: begin
            mul_req.en = 1'b1;
            mul_req.a  = MUL_A_W'(prod[39:16]);
            mul_req.b  = recip;
         end
         default: mul_req = '0;
      endcase
   end

   always_comb begin
      state_in    = state_ff;
      color_in    = color_ff;
      chan_in     = chan_ff;
      dt_in       = dt_ff;
      phase_in    = phase_ff;
      sector_in   = sector_ff;
      f_in        = f_ff;
      fs_in       = fs_ff;
      x_in        = x_ff;
      val_in      = val_ff;
      main_rgb_in = main_rgb_ff;
      comp_rgb_in = comp_rgb_ff;
      case (state_ff)
         ST_IDLE: begin
            if (ctl.start) begin
               dt_in    = elapsed_time;
               state_in = ST_ADV;
            end
         end
         ST_ADV: begin
            state_in = ST_PHASE;
         end
         ST_PHASE: begin
            phase_in = phase_ff + prod[27:12];
            color_in = 1'b0;
            state_in = ST_FRAC;
         end
         ST_FRAC: begin
            sector_in = h6[18:16];
            f_in      = h6[15:0];
            chan_in   = CH_V;
            state_in  = ST_FS;
         end
         ST_FS: begin
            state_in = ST_FSL;
         end
         ST_FSL: begin
            fs_in    = prod[26:0];
            state_in = ST_XSEL;
         end
         ST_XSEL: begin
            case (chan_ff)
               CH_V: x_in = base;
               CH_P: x_in = base - sn_hi;
               CH_Q: x_in = base - 28'(fs_ff);
               CH_T: x_in = base - sn_hi + 28'(fs_ff);
               default: x_in = base;
            endcase
            state_in = ST_MV;
         end
         ST_MV: begin
            state_in = ST_MD;
         end
         ST_MD: begin
            state_in = ST_QUO;
         end
         ST_QUO: begin
            val_in[chan_ff] = qsat;
            if (chan_ff == CH_T) begin
               state_in = ST_MAP;
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = ST_XSEL;
            end
         end
         ST_MAP: begin
            if (color_ff) begin
               comp_rgb_in = rgb_sel;
               state_in    = ST_DONE;
            end else begin
               main_rgb_in = rgb_sel;
               color_in    = 1'b1;
               state_in    = ST_FRAC;
            end
         end
         ST_DONE: begin
            if (ctl.ack) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         color_ff <= 1'b0;
         chan_ff  <= CH_V;
         phase_ff <= 16'h0000;
      end else begin
         state_ff <= state_in;
         color_ff <= color_in;
         chan_ff  <= chan_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff       <= dt_in;
      sector_ff   <= sector_in;
      f_ff        <= f_in;
      fs_ff       <= fs_in;
      x_ff        <= x_in;
      val_ff      <= val_in;
      main_rgb_ff <= main_rgb_in;
      comp_rgb_ff <= comp_rgb_in;
   end

   assign stat.idle = (state_ff == ST_IDLE);
   assign stat.done = (state_ff == ST_DONE);
   assign main_rgb  = main_rgb_ff;
   assign comp_rgb  = comp_rgb_ff;

   `HCCG_ASSERT_IMP(a_mul_issue_state, clock, reset, mul_req.en,
      (state_ff == ST_ADV) || (state_ff == ST_FS) || (state_ff == ST_MV) || (state_ff == ST_MD))
   `HCCG_ASSERT_NXT(a_mv_then_md, clock, reset, state_ff == ST_MV, state_ff == ST_MD)
   `HCCG_ASSERT_IMP(a_frac_after_map_or_phase, clock, reset, state_ff == ST_FRAC,
      (chan_ff == CH_V) || (chan_ff == CH_T))
   `HCCG_ASSERT_NXT(a_done_holds, clock, reset, (state_ff == ST_DONE) && !ctl.ack,
      (state_ff == ST_DONE) && $stable(main_rgb_ff) && $stable(comp_rgb_ff))
   `HCCG_ASSERT_NXT(a_phase_only_updates, clock, reset, state_ff != ST_PHASE,
      $stable(phase_ff))

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

   localparam logic [3:0] ADDR_HUE_SPEED  = 4'h0;
   localparam logic [3:0] ADDR_SATURATION = 4'h4;
   localparam logic [3:0] ADDR_BRIGHTNESS = 4'h8;
   localparam logic [3:0] ADDR_UNUSED     = 4'hC;
   localparam int         CYCLE_LIMIT     = 600000;
   localparam int         SETTLE_CYCLES   = 50;

   typedef logic [5:0][7:0] color_pair_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [3:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   logic [15:0] cfg_speed = 16'd4096;
   logic [7:0]  cfg_sat = 8'd255;
   logic [7:0]  cfg_bright = 8'd200;
   logic [15:0] model_phase = '0;

   color_pair_type expected_colors[$];
   int          errors = 0;
   int          cycles = 0;
   int          hold_cycles = 0;
   bit          calm = 1'b0;
   string       field_names[6] = '{"main_red", "main_green", "main_blue",
                                   "comp_red", "comp_green", "comp_blue"};

   hue_cycle_hsv_color_generator uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top NOT OK");
         $finish;
      end
   end

   function automatic logic [7:0] channel_level(input longint unsigned vn, vd, sn, sd, k);
      longint unsigned num, den, c;
      num = 64'd255 * vn * (64'd65536 * sd - k * sn);
      den = vd * 64'd65536 * sd;
      c = num / den;
      return (c > 64'd255) ? 8'd255 : c[7:0];
   endfunction

   function automatic logic [23:0] hsv_to_rgb(input logic [15:0] phase,
                                              input longint unsigned vn, vd, sn, sd);
      logic [18:0]     h6;
      longint unsigned f;
      logic [7:0]      cv, cp, cq, ct;
      h6 = 19'(phase) * 19'd6;
      f = 64'(h6[15:0]);
      cv = channel_level(vn, vd, sn, sd, 0);
      cp = channel_level(vn, vd, sn, sd, 65536);
      cq = channel_level(vn, vd, sn, sd, f);
      ct = channel_level(vn, vd, sn, sd, 65536 - f);
      case (h6[18:16])
         3'd0: return {cp, ct, cv};
         3'd1: return {cp, cv, cq};
         3'd2: return {ct, cv, cp};
         3'd3: return {cv, cq, cp};
         3'd4: return {cv, cp, ct};
         default: return {cq, cp, cv};
      endcase
   endfunction

   function automatic color_pair_type advance_hue(input logic [15:0] dt);
      logic [31:0] prod;
      logic [15:0] comp_phase;
      prod = 32'(cfg_speed) * 32'(dt);
      model_phase = model_phase + prod[27:12];
      comp_phase = model_phase + 16'h8000;
      return {hsv_to_rgb(comp_phase, 13 * longint'(cfg_bright), 2550,
                         7 * longint'(cfg_sat), 2550),
              hsv_to_rgb(model_phase, longint'(cfg_bright), 255, longint'(cfg_sat), 255)};
   endfunction

   // result checker
   always @(negedge clock) begin
      color_pair_type want, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (expected_colors.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, got);
            errors++;
         end else begin
            want = expected_colors.pop_front();
            for (int i = 0; i < 6; i++) begin
               if (want[i] !== got[i]) begin
                  $display("%0t: %s expected %0d actual %0d", $time, field_names[i],
                           want[i], got[i]);
                  errors++;
               end
            end
         end
      end
   end

   // result side ready with random stalls and a long hold on request
   initial begin
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_cycles > 0) begin
            rsp_tready <= 1'b0;
            hold_cycles--;
         end else if (!calm && stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            if (!calm && $urandom_range(0, 5) == 0) stall_left = int'($urandom_range(1, 16));
         end
      end
   end

   task automatic send_tick(input logic [15:0] dt);
      bit hit;
      req_tvalid <= 1'b1;
      req_tdata  <= dt;
      do begin
         @(negedge clock);
         hit = req_tready;
         if (hit) expected_colors.insert(expected_colors.size(), advance_hue(dt));
         @(posedge clock);
      end while (!hit);
   endtask

   task automatic idle_request(input int n);
      req_tvalid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic wait_drain();
      req_tvalid <= 1'b0;
      while (expected_colors.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_access(input logic [3:0] addr, input bit wr, input logic [31:0] value,
                             output logic [31:0] rdata);
      bit rdy;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         rdata = csr_prdata;
         @(posedge clock);
      end while (!rdy);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_write(input logic [3:0] addr, input logic [31:0] value);
      logic [31:0] unused;
      csr_access(addr, 1'b1, value, unused);
      case (addr)
         ADDR_HUE_SPEED:  cfg_speed  = value[15:0];
         ADDR_SATURATION: cfg_sat    = value[7:0];
         ADDR_BRIGHTNESS: cfg_bright = value[7:0];
         default: ;
      endcase
   endtask

   task automatic check_registers();
      logic [31:0] rd;
      logic [31:0] want[3];
      logic [3:0]  addrs[3];
      want  = '{{16'd0, cfg_speed}, {24'd0, cfg_sat}, {24'd0, cfg_bright}};
      addrs = '{ADDR_HUE_SPEED, ADDR_SATURATION, ADDR_BRIGHTNESS};
      for (int i = 0; i < 3; i++) begin
         csr_access(addrs[i], 1'b0, '0, rd);
         if (rd !== want[i]) begin
            $display("%0t: register %h expected %h actual %h", $time, addrs[i], want[i], rd);
            errors++;
         end
      end
   endtask

   // upper data bits carry noise, the block keeps only the field width
   task automatic set_colors(input logic [15:0] speed, input logic [7:0] sat,
                             input logic [7:0] bright);
      wait_drain();
      csr_write(ADDR_HUE_SPEED, {16'($urandom), speed});
      csr_write(ADDR_SATURATION, {24'($urandom), sat});
      csr_write(ADDR_BRIGHTNESS, {24'($urandom), bright});
      check_registers();
   endtask

   task automatic test_reset_values();
      check_registers();
   endtask

   task automatic test_directed();
      send_tick(16'd0);
      // one full turn in two halves wraps back to zero
      send_tick(16'd32768);
      send_tick(16'd32768);
      // walk through all six sectors
      repeat (6) send_tick(16'd10923);
      send_tick(16'hFFFF);
      send_tick(16'hAAAA);
      send_tick(16'h5555);
      // biggest advance and overlay clamp
      set_colors(16'hFFFF, 8'd255, 8'd255);
      send_tick(16'hFFFF);
      send_tick(16'h1234);
      // frozen hue, black
      set_colors(16'd0, 8'd0, 8'd0);
      send_tick(16'hFFFF);
      // grey, overlay at full value
      set_colors(16'd4096, 8'd0, 8'd255);
      send_tick(16'd20000);
      // write to an address with no register
      wait_drain();
      csr_write(ADDR_UNUSED, $urandom);
      check_registers();
      send_tick(16'd7000);
      send_tick(16'd40000);
   endtask

   task automatic random_ticks(input int n, input bit gaps);
      logic [15:0] dt;
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 3) == 0) dt = 16'($urandom_range(0, 255));
         else dt = 16'($urandom_range(0, 65535));
         send_tick(dt);
         if (gaps && !calm && $urandom_range(0, 3) == 0) begin
            idle_request(int'($urandom_range(1, 16)));
         end
      end
   endtask

   task automatic test_random_settings();
      logic [15:0] speed;
      logic [7:0]  sat, bright;
      for (int p = 0; p < 8; p++) begin
         speed  = 16'($urandom);
         sat    = 8'($urandom);
         bright = 8'($urandom);
         case (p)
            0: begin speed = 16'hFFFF; sat = 8'd255; bright = 8'd255; end
            1: begin speed = 16'd0; sat = 8'd0; bright = 8'd0; end
            2: sat = 8'd0;
            3: begin sat = 8'd255; bright = 8'd255; end
            4: speed = 16'($urandom_range(0, 4096));
            default: ;
         endcase
         set_colors(speed, sat, bright);
         random_ticks(60, 1'b1);
         // sender waits for every outstanding result
         wait_drain();
         random_ticks(55, 1'b1);
      end
   endtask

   task automatic test_backpressure();
      set_colors(16'($urandom), 8'($urandom), 8'($urandom));
      hold_cycles = 400;
      random_ticks(12, 1'b0);
      wait_drain();
   endtask

   task automatic test_steady_stream();
      set_colors(16'($urandom), 8'($urandom), 8'($urandom));
      calm = 1'b1;
      random_ticks(80, 1'b0);
      wait_drain();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_directed();
      test_random_settings();
      test_backpressure();
      test_steady_stream();
      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_colors.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, expected_colors.size());
         errors++;
      end
      if (errors == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
